// ===== rtl/core/comment_and_literal_marker_unit_macros.svh =====
// Assertion macros shared by the comment and literal marker checks.
`ifndef COMMENT_AND_LITERAL_MARKER_UNIT_MACROS_SVH
`define COMMENT_AND_LITERAL_MARKER_UNIT_MACROS_SVH

// Check a property at each rising edge, skipped while reset is high.
`define CMLM_ASSERT_RUN(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("cmlm check failed");

// Check a property at each rising edge, reset included.
`define CMLM_ASSERT_ALL(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("cmlm reset check failed");

`endif

// ===== rtl/core/cmlm_pkg.sv =====
// Package with types, codes and byte constants of the comment and literal marker.
package cmlm_pkg;

  localparam int QUEUE_DEPTH_DEFAULT = 4;

  localparam logic [7:0] MARK_ADD   = 8'h80;
  localparam logic [7:0] SPACE_BYTE = 8'h20;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_QUOTE   = 8'h27;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  typedef enum logic [1:0] {
    ERR_OK      = 2'd0,
    ERR_HIGH    = 2'd1,
    ERR_CTRL    = 2'd2,
    ERR_ESC_END = 2'd3
  } err_t;

  typedef enum logic [4:0] {
    MODE_CODE  = 5'b00001,
    MODE_CHAR  = 5'b00010,
    MODE_STR   = 5'b00100,
    MODE_LINE  = 5'b01000,
    MODE_BLOCK = 5'b10000
  } mode_t;

  // One accepted byte's results: one or two words.
  typedef struct packed {
    logic       two;
    logic [7:0] data0;
    err_t       err0;
    logic [7:0] data1;
    err_t       err1;
    logic       last;
  } entry_t;

endpackage

// ===== rtl/core/cmlm_front.sv =====
// Front part: accepts source bytes, tracks the lexical mode and builds result entries.
module cmlm_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // [7:0] src_byte
  input  logic               s_axis_tlast,   // last_byte
  input  logic               q_full,
  output logic               push,
  output cmlm_pkg::entry_t   entry
);

  cmlm_pkg::mode_t mode, mode_next;
  logic            esc, esc_next;
  logic            star, star_next;
  logic            held, held_next;

  logic            accept;
  logic [7:0]      b;
  logic            last;
  cmlm_pkg::err_t  err_hi;
  logic [7:0]      closer;
  logic            rest_v;
  logic [7:0]      rest_d;
  cmlm_pkg::err_t  rest_e;
  logic            pre;
  logic            opener;
  logic            valid;

  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign b             = s_axis_tdata;
  assign last          = s_axis_tlast;
  assign err_hi        = b[7] ? cmlm_pkg::ERR_HIGH : cmlm_pkg::ERR_OK;
  assign closer        = (mode == cmlm_pkg::MODE_CHAR) ? cmlm_pkg::CH_QUOTE
                                                       : cmlm_pkg::CH_DQUOTE;

  always_comb begin
    mode_next = mode;
    esc_next  = esc;
    star_next = star;
    held_next = held;
    rest_v    = 1'b0;
    rest_d    = b;
    rest_e    = err_hi;
    pre       = 1'b0;
    opener    = 1'b0;
    if (esc) begin
      esc_next = 1'b0;
      rest_v   = 1'b1;
      rest_d   = b + cmlm_pkg::MARK_ADD;
      rest_e   = cmlm_pkg::ERR_OK;
    end else begin
      case (mode)
        cmlm_pkg::MODE_CHAR, cmlm_pkg::MODE_STR: begin
          rest_v = 1'b1;
          if (b == closer) begin
            mode_next = cmlm_pkg::MODE_CODE;
          end else if (b == cmlm_pkg::CH_BSLASH) begin
            rest_d = b + cmlm_pkg::MARK_ADD;
            if (last) begin
              rest_e = cmlm_pkg::ERR_ESC_END;
            end else begin
              esc_next = 1'b1;
            end
          end else begin
            rest_d = b + cmlm_pkg::MARK_ADD;
            if (!b[7] && b < cmlm_pkg::SPACE_BYTE) begin
              rest_e = cmlm_pkg::ERR_CTRL;
            end
          end
        end
        cmlm_pkg::MODE_LINE: begin
          rest_v = 1'b1;
          if (b == cmlm_pkg::CH_NEWLINE) begin
            mode_next = cmlm_pkg::MODE_CODE;
          end else begin
            rest_d = cmlm_pkg::SPACE_BYTE;
          end
        end
        cmlm_pkg::MODE_BLOCK: begin
          rest_v = 1'b1;
          rest_d = cmlm_pkg::SPACE_BYTE;
          if (star && b == cmlm_pkg::CH_SLASH) begin
            mode_next = cmlm_pkg::MODE_CODE;
            star_next = 1'b0;
          end else begin
            star_next = (b == cmlm_pkg::CH_STAR);
          end
        end
        default: begin
          mode_next = cmlm_pkg::MODE_CODE;
          if (held) begin
            held_next = 1'b0;
            if (b == cmlm_pkg::CH_SLASH) begin
              mode_next = cmlm_pkg::MODE_LINE;
              opener    = 1'b1;
            end else if (b == cmlm_pkg::CH_STAR) begin
              mode_next = cmlm_pkg::MODE_BLOCK;
              star_next = 1'b0;
              opener    = 1'b1;
            end else begin
              pre = 1'b1;
            end
          end
          if (!opener) begin
            if (b == cmlm_pkg::CH_QUOTE) begin
              mode_next = cmlm_pkg::MODE_CHAR;
              rest_v    = 1'b1;
            end else if (b == cmlm_pkg::CH_DQUOTE) begin
              mode_next = cmlm_pkg::MODE_STR;
              rest_v    = 1'b1;
            end else if (b == cmlm_pkg::CH_SLASH) begin
              if (last) begin
                rest_v = 1'b1;
              end else begin
                held_next = 1'b1;
              end
            end else if (b == cmlm_pkg::CH_HASH) begin
              mode_next = cmlm_pkg::MODE_LINE;
              rest_v    = 1'b1;
              rest_d    = cmlm_pkg::SPACE_BYTE;
            end else begin
              rest_v = 1'b1;
            end
          end
        end
      endcase
    end

    entry.last = last;
    if (opener) begin
      valid       = 1'b1;
      entry.two   = 1'b1;
      entry.data0 = cmlm_pkg::SPACE_BYTE;
      entry.err0  = cmlm_pkg::ERR_OK;
      entry.data1 = cmlm_pkg::SPACE_BYTE;
      entry.err1  = cmlm_pkg::ERR_OK;
    end else if (pre) begin
      valid       = 1'b1;
      entry.two   = rest_v;
      entry.data0 = cmlm_pkg::CH_SLASH;
      entry.err0  = cmlm_pkg::ERR_OK;
      entry.data1 = rest_d;
      entry.err1  = rest_e;
    end else begin
      valid       = rest_v;
      entry.two   = 1'b0;
      entry.data0 = rest_d;
      entry.err0  = rest_e;
      entry.data1 = rest_d;
      entry.err1  = rest_e;
    end

    if (last) begin
      mode_next = cmlm_pkg::MODE_CODE;
      esc_next  = 1'b0;
      star_next = 1'b0;
      held_next = 1'b0;
    end
  end

  assign push = accept && valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= cmlm_pkg::MODE_CODE;
      esc  <= 1'b0;
      star <= 1'b0;
      held <= 1'b0;
    end else if (accept) begin
      mode <= mode_next;
      esc  <= esc_next;
      star <= star_next;
      held <= held_next;
    end
  end

endmodule

// ===== rtl/core/cmlm_queue.sv =====
// Short queue of result entries between the front and back parts.
module cmlm_queue #(
  parameter int DEPTH = cmlm_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  cmlm_pkg::entry_t push_entry,
  input  logic             pop,
  output cmlm_pkg::entry_t head,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  cmlm_pkg::entry_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_FULL);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/cmlm_back.sv =====
// Back part: splits queued entries into words and drives the output register.
module cmlm_back (
  input  logic             clk,
  input  logic             rst,
  input  cmlm_pkg::entry_t head,
  input  logic             q_empty,
  output logic             pop,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [7:0] out_byte
  output logic             m_axis_tlast,   // out_last
  output logic [1:0]       m_axis_tuser    // [1:0] error_code
);

  logic           out_valid;
  logic [7:0]     out_data;
  cmlm_pkg::err_t out_err;
  logic           out_last;
  logic           pend_valid;
  logic [7:0]     pend_data;
  cmlm_pkg::err_t pend_err;
  logic           pend_last;
  logic           load;

  assign load = !out_valid || m_axis_tready;
  assign pop  = load && !pend_valid && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (load) begin
      if (pend_valid) begin
        out_valid  <= 1'b1;
        out_data   <= pend_data;
        out_err    <= pend_err;
        out_last   <= pend_last;
        pend_valid <= 1'b0;
      end else if (!q_empty) begin
        out_valid  <= 1'b1;
        out_data   <= head.data0;
        out_err    <= head.err0;
        out_last   <= head.last && !head.two;
        pend_valid <= head.two;
        pend_data  <= head.data1;
        pend_err   <= head.err1;
        pend_last  <= head.last;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tlast  = out_last;
  assign m_axis_tuser  = out_err;

endmodule

// ===== rtl/core/comment_and_literal_marker_unit.sv =====
// Top level of the comment and literal marker.
// Takes C source on the s_axis channel, one byte per word, tlast on the final
// byte. Gives the rewritten bytes on the m_axis channel: comments turn into
// spaces, literal bytes carry 0x80, tuser holds the error code of each word.
// A byte enters every cycle while the entry queue has room. A byte yields
// zero, one or two words: a '/' in code is held until the next byte, and a
// held '/' can come out together with the byte after it, or both become
// spaces of a comment opener. A byte's words pass through the entry queue
// and then the output register to m_axis. The output gives one word per
// cycle while m_axis_tready is high; a byte that gives two words holds the
// back end for both, so a run of such bytes fills the entry queue
// (QUEUE_DEPTH entries) and s_axis_tready drops until the back end catches up.
// When m_axis_tready is low the output word holds, the back end stops taking
// entries, and s_axis_tready falls once the queue is full.
// Reset clears the lexical mode, the queue and the output register; after the
// final byte of a source the mode returns to code for the next source.
module comment_and_literal_marker_unit #(
  parameter int QUEUE_DEPTH = cmlm_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] src_byte
  input  logic       s_axis_tlast,   // last_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast,   // out_last
  output logic [1:0] m_axis_tuser    // [1:0] error_code
);

  cmlm_pkg::entry_t push_entry;
  cmlm_pkg::entry_t head;
  logic             push;
  logic             pop;
  logic             q_full;
  logic             q_empty;

  cmlm_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .q_full        (q_full),
    .push          (push),
    .entry         (push_entry)
  );

  cmlm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .full       (q_full),
    .empty      (q_empty)
  );

  cmlm_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .q_empty       (q_empty),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// ===== rtl/core/cmlm_checker.sv =====
// Port checks of the comment and literal marker, bound to the top level.
`include "comment_and_literal_marker_unit_macros.svh"

module cmlm_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic [1:0] m_axis_tuser
);

  logic        out_stall;
  logic [10:0] out_bus;

  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_bus   = {m_axis_tdata, m_axis_tlast, m_axis_tuser};

  `CMLM_ASSERT_ALL(a_reset_clears_output, clk, rst |=> !m_axis_tvalid)
  `CMLM_ASSERT_RUN(a_stall_holds, clk, rst, out_stall |=> (m_axis_tvalid && $stable(out_bus)))
  `CMLM_ASSERT_RUN(a_esc_end_word, clk, rst, (m_axis_tvalid && m_axis_tuser == cmlm_pkg::ERR_ESC_END) |-> (m_axis_tdata == 8'hDC && m_axis_tlast))
  `CMLM_ASSERT_RUN(a_ctrl_marked, clk, rst, (m_axis_tvalid && m_axis_tuser == cmlm_pkg::ERR_CTRL) |-> (m_axis_tdata[7:5] == 3'b100))

endmodule

bind comment_and_literal_marker_unit cmlm_checker u_cmlm_checker (.*);

// ===== tb/tb_comment_and_literal_marker_unit.sv =====
// Testbench for comment_and_literal_marker_unit: random C-like streams checked against a predictor.
module tb_comment_and_literal_marker_unit;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_BYTES = 305;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } src_word_t;

  typedef struct packed {
    logic [7:0]     data;
    logic           last;
    cmlm_pkg::err_t err;
  } mark_word_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;
  logic       s_axis_tlast = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;
  logic [1:0] m_axis_tuser;

  src_word_t  src_q[$];
  mark_word_t marked_q[$];
  logic [7:0] tok_q[$];

  cmlm_pkg::mode_t lex = cmlm_pkg::MODE_CODE;
  logic  esc_pend = 1'b0;
  logic  star_prev = 1'b0;
  logic  slash_wait = 1'b0;
  int    words_this_byte;

  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   hold_reqs = 0;
  int   holds_done = 0;
  int   hold_left = 0;
  logic in_taken = 1'b0;
  int   stall_cnt = 0;
  int   errors = 0;

  comment_and_literal_marker_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk = ~clk;

  function automatic void add_word(input logic [7:0] d, input cmlm_pkg::err_t e);
    mark_word_t w;
    w = '{data: d, last: 1'b0, err: e};
    marked_q.push_back(w);
    words_this_byte++;
  endfunction

  function automatic void predict_marks(input logic [7:0] b, input logic lst);
    cmlm_pkg::err_t e;
    logic [7:0]     closer;
    logic           opened;
    mark_word_t     w;
    words_this_byte = 0;
    if (esc_pend) begin
      esc_pend = 1'b0;
      add_word(b + cmlm_pkg::MARK_ADD, cmlm_pkg::ERR_OK);
    end else begin
      e = b[7] ? cmlm_pkg::ERR_HIGH : cmlm_pkg::ERR_OK;
      case (lex)
        cmlm_pkg::MODE_CHAR, cmlm_pkg::MODE_STR: begin
          closer = (lex == cmlm_pkg::MODE_CHAR) ? cmlm_pkg::CH_QUOTE : cmlm_pkg::CH_DQUOTE;
          if (b == closer) begin
            lex = cmlm_pkg::MODE_CODE;
            add_word(b, e);
          end else if (b == cmlm_pkg::CH_BSLASH) begin
            if (lst) e = cmlm_pkg::ERR_ESC_END;
            else esc_pend = 1'b1;
            add_word(b + cmlm_pkg::MARK_ADD, e);
          end else begin
            if (e == cmlm_pkg::ERR_OK && b < cmlm_pkg::SPACE_BYTE) e = cmlm_pkg::ERR_CTRL;
            add_word(b + cmlm_pkg::MARK_ADD, e);
          end
        end
        cmlm_pkg::MODE_LINE: begin
          if (b == cmlm_pkg::CH_NEWLINE) begin
            lex = cmlm_pkg::MODE_CODE;
            add_word(b, e);
          end else begin
            add_word(cmlm_pkg::SPACE_BYTE, e);
          end
        end
        cmlm_pkg::MODE_BLOCK: begin
          if (star_prev && b == cmlm_pkg::CH_SLASH) begin
            lex = cmlm_pkg::MODE_CODE;
            star_prev = 1'b0;
          end else begin
            star_prev = (b == cmlm_pkg::CH_STAR);
          end
          add_word(cmlm_pkg::SPACE_BYTE, e);
        end
        default: begin
          lex = cmlm_pkg::MODE_CODE;
          opened = 1'b0;
          if (slash_wait) begin
            slash_wait = 1'b0;
            if (b == cmlm_pkg::CH_SLASH || b == cmlm_pkg::CH_STAR) begin
              if (b == cmlm_pkg::CH_SLASH) begin
                lex = cmlm_pkg::MODE_LINE;
              end else begin
                lex = cmlm_pkg::MODE_BLOCK;
                star_prev = 1'b0;
              end
              add_word(cmlm_pkg::SPACE_BYTE, cmlm_pkg::ERR_OK);
              add_word(cmlm_pkg::SPACE_BYTE, cmlm_pkg::ERR_OK);
              opened = 1'b1;
            end else begin
              add_word(cmlm_pkg::CH_SLASH, cmlm_pkg::ERR_OK);
            end
          end
          if (!opened) begin
            if (b == cmlm_pkg::CH_QUOTE) begin
              lex = cmlm_pkg::MODE_CHAR;
              add_word(b, e);
            end else if (b == cmlm_pkg::CH_DQUOTE) begin
              lex = cmlm_pkg::MODE_STR;
              add_word(b, e);
            end else if (b == cmlm_pkg::CH_SLASH) begin
              if (lst) add_word(b, e);
              else slash_wait = 1'b1;
            end else if (b == cmlm_pkg::CH_HASH) begin
              lex = cmlm_pkg::MODE_LINE;
              add_word(cmlm_pkg::SPACE_BYTE, e);
            end else begin
              add_word(b, e);
            end
          end
        end
      endcase
    end
    if (lst) begin
      if (words_this_byte > 0) begin
        w = marked_q.pop_back();
        w.last = 1'b1;
        marked_q.push_back(w);
      end
      lex = cmlm_pkg::MODE_CODE;
      esc_pend = 1'b0;
      star_prev = 1'b0;
      slash_wait = 1'b0;
    end
  endfunction

  task automatic report_diff(input string field, input int want, input int got);
    errors++;
    $display("%0t %s mismatch: expected %0h, got %0h", $time, field, want, got);
  endtask

  // sample handshakes, predict and check
  always @(posedge clk) begin : mon
    mark_word_t got;
    mark_word_t want;
    logic       out_taken;
    if (rst) begin
      in_taken = 1'b0;
      stall_cnt = 0;
    end else begin
      in_taken = s_axis_tvalid && s_axis_tready;
      out_taken = m_axis_tvalid && m_axis_tready;
      if (in_taken) predict_marks(s_axis_tdata, s_axis_tlast);
      if (out_taken) begin
        got = '{data: m_axis_tdata, last: m_axis_tlast,
                err: cmlm_pkg::err_t'(m_axis_tuser)};
        if (marked_q.size() == 0) begin
          errors++;
          $display("%0t unexpected word: expected none, got %0h last %0b err %0d",
                   $time, got.data, got.last, got.err);
        end else begin
          want = marked_q.pop_front();
          if (got.data !== want.data) report_diff("out_byte", want.data, got.data);
          if (got.last !== want.last) report_diff("out_last", want.last, got.last);
          if (got.err !== want.err) report_diff("error_code", want.err, got.err);
        end
      end
      if (in_taken || out_taken) stall_cnt = 0;
      else if (src_q.size() > 0 || marked_q.size() > 0 || s_axis_tvalid) stall_cnt++;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // feed source bytes
  always @(negedge clk) begin : drv
    src_word_t w;
    if (!rst && (!s_axis_tvalid || in_taken)) begin
      if (src_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        w = src_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w.data;
        s_axis_tlast  <= w.last;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // drain results, with random stalls and long hold-offs on request
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_done < hold_reqs) begin
      m_axis_tready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic put(input logic [7:0] b, input logic lst);
    src_word_t w;
    w = '{data: b, last: lst};
    src_q.push_back(w);
  endtask

  function automatic logic [7:0] printable();
    return 8'($urandom_range(32, 126));
  endfunction

  // literal body bytes and closer: mostly text, some escapes, control and high bytes
  task automatic lit_body(input logic [7:0] closer);
    int k;
    int n;
    n = $urandom_range(0, 6);
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 9);
      if (k < 6) begin
        tok_q.push_back(printable());
      end else if (k < 8) begin
        tok_q.push_back(cmlm_pkg::CH_BSLASH);
        tok_q.push_back(8'($urandom_range(0, 255)));
      end else if (k == 8) begin
        tok_q.push_back(8'($urandom_range(0, 31)));
      end else begin
        tok_q.push_back(8'($urandom_range(128, 255)));
      end
    end
    tok_q.push_back(closer);
  endtask

  task automatic gen_source();
    int len;
    int kind;
    int n;
    bit cut;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 40);
    cut = 1'b0;
    tok_q.delete();
    while (tok_q.size() < len && !cut) begin
      kind = $urandom_range(0, 19);
      n = $urandom_range(1, 6);
      if (kind < 5) begin
        for (int i = 0; i < n; i++) tok_q.push_back(8'($urandom_range(97, 122)));
      end else if (kind == 5) begin
        tok_q.push_back(($urandom_range(1) == 1) ? cmlm_pkg::CH_NEWLINE
                                                 : cmlm_pkg::SPACE_BYTE);
      end else if (kind == 6 || kind == 7) begin
        tok_q.push_back(($urandom_range(2) == 0) ? cmlm_pkg::CH_HASH : cmlm_pkg::CH_SLASH);
        if (tok_q[tok_q.size() - 1] == cmlm_pkg::CH_SLASH) tok_q.push_back(cmlm_pkg::CH_SLASH);
        for (int i = 0; i < n; i++) tok_q.push_back(printable());
        tok_q.push_back(cmlm_pkg::CH_NEWLINE);
      end else if (kind == 8 || kind == 9) begin
        tok_q.push_back(cmlm_pkg::CH_SLASH);
        tok_q.push_back(cmlm_pkg::CH_STAR);
        for (int i = 0; i < n; i++) begin
          case ($urandom_range(0, 3))
            0: tok_q.push_back(cmlm_pkg::CH_STAR);
            1: tok_q.push_back(8'($urandom_range(0, 255)));
            default: tok_q.push_back(printable());
          endcase
        end
        tok_q.push_back(cmlm_pkg::CH_STAR);
        tok_q.push_back(cmlm_pkg::CH_SLASH);
      end else if (kind == 10 || kind == 11) begin
        tok_q.push_back(cmlm_pkg::CH_DQUOTE);
        lit_body(cmlm_pkg::CH_DQUOTE);
      end else if (kind == 12) begin
        tok_q.push_back(cmlm_pkg::CH_QUOTE);
        lit_body(cmlm_pkg::CH_QUOTE);
      end else if (kind == 13) begin
        tok_q.push_back(8'($urandom_range(97, 122)));
        tok_q.push_back(cmlm_pkg::CH_SLASH);
        tok_q.push_back(printable());
      end else if (kind == 14) begin
        for (int i = 0; i < n; i++) tok_q.push_back(8'($urandom_range(0, 255)));
      end else if (kind == 15) begin
        tok_q.push_back(($urandom_range(1) == 1) ? cmlm_pkg::CH_DQUOTE : cmlm_pkg::CH_QUOTE);
        tok_q.push_back(cmlm_pkg::CH_BSLASH);
        cut = 1'b1;
      end else begin
        case ($urandom_range(0, 5))
          0: tok_q.push_back(8'h3D);
          1: tok_q.push_back(8'h3B);
          2: tok_q.push_back(8'h28);
          3: tok_q.push_back(8'h29);
          4: tok_q.push_back(cmlm_pkg::CH_STAR);
          default: tok_q.push_back(8'h2B);
        endcase
      end
    end
    n = cut ? tok_q.size() : len;
    for (int i = 0; i < n; i++) put(tok_q[i], i == n - 1);
  endtask

  task automatic drain();
    while (src_q.size() > 0 || s_axis_tvalid || marked_q.size() > 0) @(posedge clk);
  endtask

  initial begin
    int sent;
    int idle_pct[4];
    int stall_pct[4];
    idle_pct  = '{0, 68, 0, 24};
    stall_pct = '{0, 0, 68, 24};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    put(8'h78, 1'b0); put(cmlm_pkg::CH_SLASH, 1'b0); put(8'h79, 1'b0);
    put(cmlm_pkg::CH_SLASH, 1'b0); put(cmlm_pkg::CH_SLASH, 1'b0);
    put(8'h63, 1'b0); put(cmlm_pkg::CH_NEWLINE, 1'b0);
    put(cmlm_pkg::CH_SLASH, 1'b0); put(cmlm_pkg::CH_STAR, 1'b0);
    put(cmlm_pkg::CH_STAR, 1'b0); put(cmlm_pkg::CH_SLASH, 1'b0);
    put(cmlm_pkg::CH_HASH, 1'b0); put(8'h7A, 1'b0); put(cmlm_pkg::CH_NEWLINE, 1'b0);
    put(cmlm_pkg::CH_QUOTE, 1'b0); put(cmlm_pkg::CH_BSLASH, 1'b0);
    put(cmlm_pkg::CH_QUOTE, 1'b0); put(cmlm_pkg::CH_QUOTE, 1'b0);
    put(cmlm_pkg::CH_DQUOTE, 1'b0); put(8'h01, 1'b0); put(8'hFF, 1'b0);
    put(cmlm_pkg::CH_BSLASH, 1'b0); put(8'hFF, 1'b0); put(cmlm_pkg::CH_DQUOTE, 1'b0);
    put(8'h80, 1'b0); put(cmlm_pkg::CH_DQUOTE, 1'b0); put(cmlm_pkg::CH_BSLASH, 1'b1);
    put(cmlm_pkg::CH_SLASH, 1'b1);
    put(8'h00, 1'b1);
    drain();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_pct[p];
      recv_stall_pct = stall_pct[p];
      sent = src_q.size();
      while (src_q.size() - sent < PHASE_BYTES) gen_source();
      drain();
    end

    // hold the output while double-word bytes keep arriving
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_reqs = hold_reqs + 1;
    for (int i = 0; i < 60; i++) begin
      put(cmlm_pkg::CH_SLASH, 1'b0);
      put(8'($urandom_range(97, 122)), i == 59);
    end
    drain();

    repeat (20) @(posedge clk);
    if (errors == 0 && marked_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== comment_and_literal_marker_unit.f =====
+incdir+rtl/core
rtl/core/cmlm_pkg.sv
rtl/core/cmlm_front.sv
rtl/core/cmlm_queue.sv
rtl/core/cmlm_back.sv
rtl/core/comment_and_literal_marker_unit.sv
rtl/core/cmlm_checker.sv
tb/tb_comment_and_literal_marker_unit.sv
